>>> design/fthc_pkg.sv
// Shared types and constants for the flow throughput fairness classifier.
// Used by every module of the block; no dependencies.
package fthc_pkg;

  // Flow table geometry (flow count is a power of two: mean is a shift)
  localparam int FLOW_COUNT = 32;
  localparam int FLOW_BITS  = $clog2(FLOW_COUNT);
  localparam int CNT_W      = FLOW_BITS + 1;
  localparam int SUM_W      = 32 + FLOW_BITS;

  // Iterative units
  localparam int DIV_STEPS  = 64;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int SQRT_STEPS = 32;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

  // Fixed-point scaling: bytes * 8 * 2^16 is a shift by 19
  localparam int RATE_SHIFT = 19;
  localparam int BETA_FRAC  = 8;
  localparam logic [16:0] GAMMA_ONE = 17'h10000;

  // Register reset values
  localparam logic [26:0] PORT_BW_RST = 27'd120000;
  localparam logic [15:0] BETA_RST    = 16'd64;
  localparam logic [16:0] GAMMA_RST   = 17'd0;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_PORT_BW  = 2'd0,
    REG_BETA     = 2'd1,
    REG_GAMMA    = 2'd2,
    REG_TCP_ONLY = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [26:0] port_bw;
    logic [15:0] beta;
    logic [16:0] gamma;
    logic        tcp_only;
  } cfg_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic                 load_item;
    logic                 clr_acc;
    logic                 rate_div;
    logic                 rate_write;
    logic                 mean_load;
    logic                 var_diff;
    logic                 var_square;
    logic                 var_acc;
    logic                 sqrt_init;
    logic                 sqrt_step;
    logic                 bsd_load;
    logic                 class_step;
    logic                 avg_div;
    logic                 avg_load;
    logic                 eq_load;
    logic                 w_load;
    logic                 lng_load;
    logic                 emit;
    logic                 last;
    logic [FLOW_BITS-1:0] idx;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic first_round;
    logic div_done;
  } dp_sts_t;

endpackage

>>> design/fthc_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit.
// Depends on fthc_pkg.
module fthc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import fthc_pkg::*;

  logic                 running;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          rem;
  logic [63:0]          quo;
  logic [31:0]          dsr;
  logic [33:0]          trial;
  logic                 fits;

  // Trial subtract of the shifted remainder
  assign trial = {1'b0, rem, quo[63]} - {2'b00, dsr};
  assign fits  = ~trial[33];
  assign quotient = quo;

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Shift remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (running) begin
      rem <= fits ? trial[31:0] : {rem[30:0], quo[63]};
      quo <= {quo[62:0], fits};
    end
  end

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (rst) running |-> !start)
    else $error("divider restarted while running");
  a_done_ends: assert property (@(posedge clk) disable iff (rst) done |-> !running)
    else $error("divider done while still running");
  a_steps: assert property (@(posedge clk) disable iff (rst)
    (running && cnt == DIV_CNT_W'(DIV_STEPS - 1) && !start) |=> done)
    else $error("divider missed its last step");
`endif

endmodule

>>> design/fthc_datapath.sv
// Datapath: counter tables, rate divider, statistics, root and queue split.
// Depends on fthc_pkg and fthc_div.
module fthc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  fthc_pkg::dp_cmd_t  cmd,
  input  fthc_pkg::cfg_t     cfg,
  input  logic [4:0]         flow_index,
  input  logic [31:0]        byte_count,
  input  logic [31:0]        interval_us,
  output fthc_pkg::dp_sts_t  sts,
  output logic               result_valid,
  output logic [4:0]         flow_number,
  output logic               queue_choice,
  output logic [31:0]        flow_rate,
  output logic [26:0]        long_queue_rate,
  output logic [26:0]        short_queue_rate,
  output logic               last_flow
);
  import fthc_pkg::*;

  logic [31:0] current_counts [FLOW_COUNT];
  logic [31:0] previous_counts [FLOW_COUNT];
  logic [31:0] flow_rates [FLOW_COUNT];
  logic [FLOW_COUNT-1:0] q0;
  logic        first_round;
  logic [31:0] round_interval;

  logic [SUM_W-1:0] sum;
  logic [31:0] mean;
  logic [31:0] var_d;
  logic [63:0] var_sq;
  logic [63:0] var_acc;
  logic [63:0] sq_v, sq_res, sq_bit, sq_tb;
  logic [39:0] bsd;
  logic [SUM_W-1:0] thr_less;
  logic [CNT_W-1:0] n_less, n_long;
  logic [31:0] avg;
  logic [31+CNT_W:0] an;
  logic [43:0] eq;
  logic [54:0] m1;
  logic [60:0] m2;
  logic [26:0] lng;

  logic        div_start, div_done;
  logic [63:0] div_dividend, div_quo;
  logic [31:0] div_divisor, div_iv, diff, rate_rd, rate_val;
  logic [47:0] beta_prod;
  logic [48:0] eq_prod;
  logic [40:0] class_lhs;
  logic [16:0] g, gi;
  logic [63:0] w;
  logic [31:0] lng_full;

  // Select operands for the shared divider
  assign diff      = current_counts[cmd.idx] - previous_counts[cmd.idx];
  assign div_iv    = (round_interval == 32'd0) ? 32'd1 : round_interval;
  assign div_start = cmd.rate_div | cmd.avg_div;
  assign div_dividend = cmd.avg_div ? 64'(thr_less)
                                    : {13'd0, diff, RATE_SHIFT'(0)};
  assign div_divisor  = cmd.avg_div ? 32'(n_less) : div_iv;

  fthc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign sts.first_round = first_round;
  assign sts.div_done    = div_done;

  // Saturate the rate quotient; first round reports zero
  assign rate_val = first_round ? 32'd0 : ((|div_quo[63:32]) ? '1 : div_quo[31:0]);
  assign rate_rd  = flow_rates[cmd.idx];

  assign beta_prod = cfg.beta * sq_res[31:0];
  assign class_lhs = {9'd0, rate_rd} + {1'b0, bsd};
  assign eq_prod   = {cfg.port_bw, 16'd0} * n_long;
  assign g  = (cfg.gamma > GAMMA_ONE) ? GAMMA_ONE : cfg.gamma;
  assign gi = GAMMA_ONE - g;
  assign w  = {9'd0, m1} + {3'd0, m2};
  assign lng_full = w[63:32];
  assign sq_tb = sq_res + sq_bit;

  // Flag and interval state
  always_ff @(posedge clk) begin
    if (rst) begin
      first_round    <= 1'b1;
      round_interval <= 32'd1;
    end else begin
      if (cmd.load_item) round_interval <= interval_us;
      if (cmd.mean_load) first_round <= 1'b0;
    end
  end

  // Store readings and per-round tables
  always_ff @(posedge clk) begin
    if (cmd.load_item && (32'(flow_index) < FLOW_COUNT))
      current_counts[flow_index[FLOW_BITS-1:0]] <= byte_count;
    if (cmd.rate_write) begin
      previous_counts[cmd.idx] <= current_counts[cmd.idx];
      flow_rates[cmd.idx]      <= rate_val;
    end
  end

  // Accumulate statistics over the passes
  always_ff @(posedge clk) begin
    if (cmd.clr_acc) begin
      sum      <= '0;
      var_acc  <= '0;
      thr_less <= '0;
      n_less   <= '0;
      n_long   <= '0;
    end else begin
      if (cmd.rate_write) sum <= sum + SUM_W'(rate_val);
      if (cmd.var_acc) var_acc <= var_acc + {FLOW_BITS'(0), var_sq[63:FLOW_BITS]};
      if (cmd.class_step) begin
        if (rate_rd <= mean) begin
          thr_less <= thr_less + SUM_W'(rate_rd);
          n_less   <= n_less + 1'b1;
        end
        if (class_lhs <= {9'd0, mean}) n_long <= n_long + 1'b1;
      end
    end
    if (cmd.class_step) q0[cmd.idx] <= (class_lhs <= {9'd0, mean});
    if (cmd.mean_load) mean <= sum[SUM_W-1:FLOW_BITS];
    if (cmd.var_diff) var_d <= (rate_rd >= mean) ? rate_rd - mean : mean - rate_rd;
    if (cmd.var_square) var_sq <= var_d * var_d;
  end

  // Square root, one result bit per step
  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_v   <= var_acc;
      sq_res <= '0;
      sq_bit <= 64'd1 << 62;
    end else if (cmd.sqrt_step) begin
      if (sq_v >= sq_tb) begin
        sq_v   <= sq_v - sq_tb;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // Threshold and queue split
  always_ff @(posedge clk) begin
    if (cmd.bsd_load) bsd <= beta_prod[47:BETA_FRAC];
    if (cmd.avg_load) avg <= (n_less == '0) ? 32'd0 : div_quo[31:0];
    if (cmd.eq_load) begin
      an <= avg * n_long;
      eq <= eq_prod[48:FLOW_BITS];
    end
    if (cmd.w_load) begin
      m1 <= g * an;
      m2 <= gi * eq;
    end
    if (cmd.lng_load)
      lng <= (lng_full > 32'(cfg.port_bw)) ? cfg.port_bw : lng_full[26:0];
  end

  // Drive one result word per flow
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      flow_number      <= 5'(cmd.idx);
      queue_choice     <= ~(cfg.tcp_only | q0[cmd.idx]);
      flow_rate        <= rate_rd;
      long_queue_rate  <= lng;
      short_queue_rate <= cfg.port_bw - lng;
      last_flow        <= cmd.last;
    end
  end

endmodule

>>> design/fthc_ctrl.sv
// Controller: sequences the per-round passes over the flow table.
// Depends on fthc_pkg.
module fthc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              round_end,
  input  fthc_pkg::dp_sts_t sts,
  output logic              busy,
  output fthc_pkg::dp_cmd_t cmd
);
  import fthc_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE       = 17'h00001,
    S_RATE_ISSUE = 17'h00002,
    S_RATE_WAIT  = 17'h00004,
    S_MEAN       = 17'h00008,
    S_VAR_DIFF   = 17'h00010,
    S_VAR_SQ     = 17'h00020,
    S_VAR_ACC    = 17'h00040,
    S_SQRT_INIT  = 17'h00080,
    S_SQRT_STEP  = 17'h00100,
    S_BSD        = 17'h00200,
    S_CLASS      = 17'h00400,
    S_AVG_ISSUE  = 17'h00800,
    S_AVG_WAIT   = 17'h01000,
    S_EQ         = 17'h02000,
    S_WMUL       = 17'h04000,
    S_LNG        = 17'h08000,
    S_EMIT       = 17'h10000
  } state_t;

  localparam logic [FLOW_BITS-1:0] LAST_IDX = FLOW_BITS'(FLOW_COUNT - 1);

  state_t                state, state_next;
  logic [FLOW_BITS-1:0]  idx, idx_next;
  logic [SQRT_CNT_W-1:0] step, step_next;
  logic                  is_last;

  assign busy    = (state != S_IDLE);
  assign is_last = (idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      step  <= step_next;
    end
  end

  // Next state and command decode
  always_comb begin
    state_next = state;
    idx_next   = idx;
    step_next  = step;
    cmd        = '0;
    cmd.idx    = idx;
    cmd.last   = is_last;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          if (round_end) begin
            cmd.clr_acc = 1'b1;
            idx_next    = '0;
            state_next  = S_RATE_ISSUE;
          end
        end
      end
      S_RATE_ISSUE: begin
        if (sts.first_round) begin
          cmd.rate_write = 1'b1;
          idx_next   = idx + 1'b1;
          state_next = is_last ? S_MEAN : S_RATE_ISSUE;
        end else begin
          cmd.rate_div = 1'b1;
          state_next   = S_RATE_WAIT;
        end
      end
      S_RATE_WAIT: begin
        if (sts.div_done) begin
          cmd.rate_write = 1'b1;
          idx_next   = idx + 1'b1;
          state_next = is_last ? S_MEAN : S_RATE_ISSUE;
        end
      end
      S_MEAN: begin
        cmd.mean_load = 1'b1;
        idx_next      = '0;
        state_next    = S_VAR_DIFF;
      end
      S_VAR_DIFF: begin
        cmd.var_diff = 1'b1;
        state_next   = S_VAR_SQ;
      end
      S_VAR_SQ: begin
        cmd.var_square = 1'b1;
        state_next     = S_VAR_ACC;
      end
      S_VAR_ACC: begin
        cmd.var_acc = 1'b1;
        idx_next    = idx + 1'b1;
        state_next  = is_last ? S_SQRT_INIT : S_VAR_DIFF;
      end
      S_SQRT_INIT: begin
        cmd.sqrt_init = 1'b1;
        step_next     = '0;
        state_next    = S_SQRT_STEP;
      end
      S_SQRT_STEP: begin
        cmd.sqrt_step = 1'b1;
        step_next     = step + 1'b1;
        if (step == SQRT_CNT_W'(SQRT_STEPS - 1)) state_next = S_BSD;
      end
      S_BSD: begin
        cmd.bsd_load = 1'b1;
        idx_next     = '0;
        state_next   = S_CLASS;
      end
      S_CLASS: begin
        cmd.class_step = 1'b1;
        idx_next       = idx + 1'b1;
        if (is_last) state_next = S_AVG_ISSUE;
      end
      S_AVG_ISSUE: begin
        cmd.avg_div = 1'b1;
        state_next  = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (sts.div_done) begin
          cmd.avg_load = 1'b1;
          state_next   = S_EQ;
        end
      end
      S_EQ: begin
        cmd.eq_load = 1'b1;
        state_next  = S_WMUL;
      end
      S_WMUL: begin
        cmd.w_load = 1'b1;
        state_next = S_LNG;
      end
      S_LNG: begin
        cmd.lng_load = 1'b1;
        idx_next     = '0;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        idx_next   = idx + 1'b1;
        if (is_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_RATE_WAIT || state == S_AVG_WAIT))
    else $error("divider finished outside a wait state");
  a_emit_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && is_last) |=> (state == S_IDLE))
    else $error("round did not end after the last result");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd.load_item)
    else $error("word taken while busy");
`endif

endmodule

>>> design/flow_throughput_fairness_classifier_core.sv
// Flow throughput fairness classifier: top level with the register port.
// One counter reading per start pulse; at round end, per-flow queue
// assignments are emitted one per cycle on the result ports.
//
// Input channel: a word (flow_index, byte_count, interval_us, round_end) is
// taken at a clock edge with start high and busy low. A word without
// round_end is stored and busy stays low.
// A word with round_end raises busy for the round: the rate pass runs the
// shared serial divider once per flow (in the first round it only stores
// zero rates), then come the variance pass, the square root, the
// classification, the average and split, and the results.
// Result channel: result_valid is high for exactly one cycle per flow,
// flows 0 to 31 on consecutive cycles; last_flow marks the final one. The
// receiver cannot stall, so the words must be taken as they appear.
// Registers sit on the APB port; write them only while busy is low.
// Reset (rst, synchronous) returns the registers to their defaults and
// marks the next round as the first: counters captured, rates zero.
module flow_throughput_fairness_classifier_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  flow_index,
  input  logic [31:0] byte_count,
  input  logic [31:0] interval_us,
  input  logic        round_end,
  output logic        result_valid,
  output logic [4:0]  flow_number,
  output logic        queue_choice,
  output logic [31:0] flow_rate,
  output logic [26:0] long_queue_rate,
  output logic [26:0] short_queue_rate,
  output logic        last_flow
);
  import fthc_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_sts_t  sts;
  reg_idx_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite;

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.port_bw  <= PORT_BW_RST;
      cfg.beta     <= BETA_RST;
      cfg.gamma    <= GAMMA_RST;
      cfg.tcp_only <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PORT_BW:  cfg.port_bw  <= pwdata[26:0];
        REG_BETA:     cfg.beta     <= pwdata[15:0];
        REG_GAMMA:    cfg.gamma    <= pwdata[16:0];
        REG_TCP_ONLY: cfg.tcp_only <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_sel)
      REG_PORT_BW:  prdata = 32'(cfg.port_bw);
      REG_BETA:     prdata = 32'(cfg.beta);
      REG_GAMMA:    prdata = 32'(cfg.gamma);
      REG_TCP_ONLY: prdata = 32'(cfg.tcp_only);
      default:      prdata = '0;
    endcase
  end

  fthc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .round_end (round_end),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd)
  );

  fthc_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg              (cfg),
    .flow_index       (flow_index),
    .byte_count       (byte_count),
    .interval_us      (interval_us),
    .sts              (sts),
    .result_valid     (result_valid),
    .flow_number      (flow_number),
    .queue_choice     (queue_choice),
    .flow_rate        (flow_rate),
    .long_queue_rate  (long_queue_rate),
    .short_queue_rate (short_queue_rate),
    .last_flow        (last_flow)
  );

endmodule
